[rtl/sas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_pkg
// Word types and operation codes for the sliding anagram search unit.
// ----------------------------------------------------------------------------
package sas_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_CLEAR   = 2'd0;
    localparam t_op OP_PATTERN = 2'd1;
    localparam t_op OP_TEXT    = 2'd2;

    typedef struct packed {
        t_op        operation;
        logic [7:0] symbol;
    } t_in_word;

    typedef struct packed {
        logic window_full;
        logic window_match;
        logic found;
        logic overflow;
    } t_out_word;

endpackage

[rtl/sliding_anagram_search_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_anagram_search_unit
// Anagram search over a sliding text window. Pattern and window histograms
// share one memory entry per bin; a ring memory keeps the last text bytes.
//
//   channel  | handshake                  | word
//   ---------+----------------------------+-----------
//   input    | i_in_valid / o_in_stall    | i_in_word
//   output   | o_out_valid / i_out_stall  | o_out_word
//
// Clear, overflow, unused code or text with an empty pattern go straight to done;
// a bin update runs through a bump state, and a ring byte entering or leaving the
// window adds a read and a second bump: serial read-modify-write on the histogram port.
// Synchronous reset clears control state and histogram valid bits.
// A stalled result holds in the output register; the next word is taken and
// its result waits in the last state until the register drains.
// ----------------------------------------------------------------------------
module sliding_anagram_search_unit
    import sas_pkg::*;
#(
    parameter int MAX_PATTERN = 64,
    parameter int ALPHABET    = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int SW = CW + 1;
    localparam int RW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int BW = $clog2(ALPHABET);
    localparam int MW = $clog2(ALPHABET + 1);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_BUMP_NEW = 5'b00010,
        S_RD_OLD   = 5'b00100,
        S_BUMP_OLD = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    function automatic logic [BW-1:0] bin_of(input logic [7:0] sym);
        logic [8:0] ext;
        ext = {1'b0, sym};
        if (ext >= 9'(ALPHABET)) begin
            bin_of = BW'(ALPHABET - 1);
        end else begin
            bin_of = ext[BW-1:0];
        end
    endfunction

    logic [2*CW-1:0] hist_mem [0:ALPHABET-1];
    logic [7:0]      ring_mem [0:MAX_PATTERN-1];

    t_state          r_state, n_state;
    logic [CW-1:0]   r_pl, n_pl;
    logic [CW-1:0]   r_tf, n_tf;
    logic [RW-1:0]   r_rp, n_rp;
    logic [MW-1:0]   r_mm, n_mm;
    logic            r_found, n_found;
    logic [ALPHABET-1:0] r_hist_vld, n_hist_vld;
    logic [BW-1:0]   r_hist_addr, n_hist_addr;
    logic            r_new_pat, n_new_pat;
    logic            r_old_up, n_old_up;
    logic            r_do_old, n_do_old;
    logic            r_is_text, n_is_text;
    logic            r_ovf, n_ovf;
    logic            r_out_valid, n_out_valid;
    t_out_word       r_out_word, n_out_word;

    logic [2*CW-1:0] r_hist_rdata;
    logic            r_hist_rvld;
    logic [7:0]      r_ring_rdata;

    logic            hist_re, hist_we;
    logic [BW-1:0]   hist_raddr;
    logic [2*CW-1:0] hist_wdata;
    logic            ring_re, ring_we;
    logic [RW-1:0]   ring_raddr;

    logic            in_acc;
    logic            out_free;
    logic [BW-1:0]   in_bin;
    logic [CW-1:0]   back_dist;
    logic [SW-1:0]   back;
    logic [SW-1:0]   slot;
    logic [2*CW-1:0] ent;
    logic [CW-1:0]   p_cnt, w_cnt, p_nxt, w_nxt;
    logic            bump_pat, bump_up, mis_before, mis_after;
    logic            res_full, res_match;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_bin   = bin_of(i_in_word.symbol);

    // ring slot that lies back_dist places before the write pointer
    assign back_dist = (i_in_word.operation == OP_PATTERN) ? (r_pl + CW'(1)) : r_pl;
    assign back      = SW'(r_rp) + SW'(MAX_PATTERN) - SW'(back_dist);
    assign slot      = (back >= SW'(MAX_PATTERN)) ? (back - SW'(MAX_PATTERN)) : back;

    // bin update
    assign ent        = r_hist_rvld ? r_hist_rdata : '0;
    assign p_cnt      = ent[2*CW-1:CW];
    assign w_cnt      = ent[CW-1:0];
    assign bump_pat   = (r_state == S_BUMP_NEW) && r_new_pat;
    assign bump_up    = (r_state == S_BUMP_NEW) || r_old_up;
    assign p_nxt      = bump_pat ? (p_cnt + CW'(1)) : p_cnt;
    assign w_nxt      = bump_pat ? w_cnt :
                        bump_up  ? (w_cnt + CW'(1)) :
                        (w_cnt != '0) ? (w_cnt - CW'(1)) : w_cnt;
    assign mis_before = (p_cnt != w_cnt);
    assign mis_after  = (p_nxt != w_nxt);
    assign hist_wdata = {p_nxt, w_nxt};

    assign res_full  = r_is_text && (r_tf >= r_pl);
    assign res_match = res_full && (r_mm == '0);

    always_comb begin
        n_state     = r_state;
        n_pl        = r_pl;
        n_tf        = r_tf;
        n_rp        = r_rp;
        n_mm        = r_mm;
        n_found     = r_found;
        n_hist_vld  = r_hist_vld;
        n_hist_addr = r_hist_addr;
        n_new_pat   = r_new_pat;
        n_old_up    = r_old_up;
        n_do_old    = r_do_old;
        n_is_text   = r_is_text;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        hist_re     = 1'b0;
        hist_we     = 1'b0;
        hist_raddr  = in_bin;
        ring_re     = 1'b0;
        ring_we     = 1'b0;
        ring_raddr  = slot[RW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_is_text = 1'b0;
                    n_ovf     = 1'b0;
                    n_state   = S_DONE;
                    unique case (i_in_word.operation)
                        OP_CLEAR: begin
                            n_hist_vld = '0;
                            n_mm       = '0;
                            n_rp       = '0;
                            n_pl       = '0;
                            n_tf       = '0;
                            n_found    = 1'b0;
                        end
                        OP_PATTERN: begin
                            if (r_pl >= CW'(MAX_PATTERN)) begin
                                n_ovf = 1'b1;
                            end else begin
                                hist_re   = 1'b1;
                                ring_re   = 1'b1;
                                n_pl      = r_pl + CW'(1);
                                n_do_old  = ({1'b0, r_tf} >= ({1'b0, r_pl} + SW'(1)));
                                n_new_pat = 1'b1;
                                n_old_up  = 1'b1;
                                n_state   = S_BUMP_NEW;
                            end
                        end
                        OP_TEXT: begin
                            n_is_text = 1'b1;
                            ring_we   = 1'b1;
                            n_rp      = (r_rp == RW'(MAX_PATTERN - 1)) ? '0 : (r_rp + RW'(1));
                            if (r_tf < CW'(MAX_PATTERN)) begin
                                n_tf = r_tf + CW'(1);
                            end
                            if (r_pl != '0) begin
                                hist_re   = 1'b1;
                                ring_re   = 1'b1;
                                n_do_old  = (r_tf >= r_pl);
                                n_new_pat = 1'b0;
                                n_old_up  = 1'b0;
                                n_state   = S_BUMP_NEW;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (hist_re) begin
                        n_hist_addr = hist_raddr;
                    end
                end
            end
            S_BUMP_NEW, S_BUMP_OLD: begin
                hist_we = 1'b1;
                n_hist_vld[r_hist_addr] = 1'b1;
                if (mis_after && !mis_before) begin
                    n_mm = r_mm + MW'(1);
                end else if (mis_before && !mis_after && (r_mm != '0)) begin
                    n_mm = r_mm - MW'(1);
                end
                n_state = ((r_state == S_BUMP_NEW) && r_do_old) ? S_RD_OLD : S_DONE;
            end
            S_RD_OLD: begin
                hist_re     = 1'b1;
                hist_raddr  = bin_of(r_ring_rdata);
                n_hist_addr = hist_raddr;
                n_state     = S_BUMP_OLD;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_found                 = r_found || res_match;
                    n_out_word.window_full  = res_full;
                    n_out_word.window_match = res_match;
                    n_out_word.found        = r_found || res_match;
                    n_out_word.overflow     = r_ovf;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pl        <= '0;
            r_tf        <= '0;
            r_rp        <= '0;
            r_mm        <= '0;
            r_found     <= 1'b0;
            r_hist_vld  <= '0;
            r_new_pat   <= 1'b0;
            r_old_up    <= 1'b0;
            r_do_old    <= 1'b0;
            r_is_text   <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pl        <= n_pl;
            r_tf        <= n_tf;
            r_rp        <= n_rp;
            r_mm        <= n_mm;
            r_found     <= n_found;
            r_hist_vld  <= n_hist_vld;
            r_new_pat   <= n_new_pat;
            r_old_up    <= n_old_up;
            r_do_old    <= n_do_old;
            r_is_text   <= n_is_text;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hist_addr <= n_hist_addr;
        r_out_word  <= n_out_word;
    end

    // histogram memory: {pattern count, window count} per bin
    always_ff @(posedge i_clk) begin
        if (hist_re) begin
            r_hist_rdata <= hist_mem[hist_raddr];
            r_hist_rvld  <= r_hist_vld[hist_raddr];
        end
        if (hist_we) begin
            hist_mem[r_hist_addr] <= hist_wdata;
        end
    end

    // text ring; a read at the write slot returns the old byte
    always_ff @(posedge i_clk) begin
        if (ring_re) begin
            r_ring_rdata <= ring_mem[ring_raddr];
        end
        if (ring_we) begin
            ring_mem[r_rp] <= i_in_word.symbol;
        end
    end

endmodule

[bench/tb_sliding_anagram_search_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_anagram_search_unit
// Self-checking bench for the sliding anagram search unit. A queue of input
// words feeds a valid/stall driver. Each accepted word runs through a local
// model of the pattern and window histograms, and the model's flags are
// queued. Each accepted result is compared field by field with the oldest
// queued flags. The run covers directed corner cases first, then random
// pattern/text searches with planted anagrams and noise, under several
// source idle and sink stall mixes.
// ----------------------------------------------------------------------------
module tb_sliding_anagram_search_unit
    import sas_pkg::*;
;

    localparam int MAX_PATTERN = 64;
    localparam int ALPHABET    = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 120;
    localparam t_op OP_UNUSED  = 2'd3;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    sliding_anagram_search_unit #(
        .MAX_PATTERN(MAX_PATTERN),
        .ALPHABET   (ALPHABET)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    t_in_word  search_words[$];
    t_out_word expected_flags[$];
    int        queued_total   = 0;
    int        mismatch_count = 0;
    int        results_seen   = 0;
    int        cycle_count    = 0;
    int        idle_pct       = 0;
    int        stall_pct      = 0;
    bit        draining       = 1'b0;
    bit        in_taken       = 1'b0;

    // search state
    int pattern_count [ALPHABET];
    int window_count  [ALPHABET];
    int ring_bytes    [MAX_PATTERN];
    int diff_bins   = 0;
    int ring_slot   = 0;
    int pattern_len = 0;
    int text_seen   = 0;
    bit found_seen  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int bin_index(int sym);
        return (sym >= ALPHABET) ? ALPHABET - 1 : sym;
    endfunction

    function automatic void adjust_bin(bit in_window, int bin, bit up);
        bit was_diff;
        bit now_diff;
        was_diff = window_count[bin] != pattern_count[bin];
        if (in_window) begin
            if (up) window_count[bin]++;
            else if (window_count[bin] != 0) window_count[bin]--;
        end else begin
            if (up) pattern_count[bin]++;
            else if (pattern_count[bin] != 0) pattern_count[bin]--;
        end
        now_diff = window_count[bin] != pattern_count[bin];
        if (now_diff && !was_diff) diff_bins++;
        else if (was_diff && !now_diff && diff_bins != 0) diff_bins--;
    endfunction

    function automatic int leaving_byte();
        int slot;
        slot = (ring_slot + MAX_PATTERN - (pattern_len % MAX_PATTERN)) % MAX_PATTERN;
        return bin_index(ring_bytes[slot]);
    endfunction

    function automatic t_out_word anagram_step(t_in_word w);
        t_out_word r;
        r = '0;
        case (w.operation)
            OP_CLEAR: begin
                foreach (pattern_count[k]) begin
                    pattern_count[k] = 0;
                    window_count[k]  = 0;
                end
                diff_bins   = 0;
                ring_slot   = 0;
                pattern_len = 0;
                text_seen   = 0;
                found_seen  = 1'b0;
            end
            OP_PATTERN: begin
                if (pattern_len >= MAX_PATTERN) begin
                    r.overflow = 1'b1;
                end else begin
                    adjust_bin(1'b0, bin_index(int'(w.symbol)), 1'b1);
                    pattern_len++;
                    if (text_seen >= pattern_len) adjust_bin(1'b1, leaving_byte(), 1'b1);
                end
            end
            OP_TEXT: begin
                if (pattern_len != 0) begin
                    adjust_bin(1'b1, bin_index(int'(w.symbol)), 1'b1);
                    if (text_seen >= pattern_len) adjust_bin(1'b1, leaving_byte(), 1'b0);
                end
                ring_bytes[ring_slot] = int'(w.symbol);
                ring_slot = (ring_slot + 1) % MAX_PATTERN;
                if (text_seen < MAX_PATTERN) text_seen++;
                r.window_full  = text_seen >= pattern_len;
                r.window_match = r.window_full && (diff_bins == 0);
                if (r.window_match) found_seen = 1'b1;
            end
            default: begin
            end
        endcase
        r.found = found_seen;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic got, logic want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %b want %b",
                                      results_seen, name, got, want));
    endtask

    // monitor: results first, then accepted words into the model
    always @(posedge i_clk) begin
        t_out_word want;
        cycle_count++;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (expected_flags.size() == 0) begin
                    report_mismatch("result with no pending word");
                end else begin
                    want = expected_flags.pop_front();
                    check_field("window_full",  o_out_word.window_full,  want.window_full);
                    check_field("window_match", o_out_word.window_match, want.window_match);
                    check_field("found",        o_out_word.found,        want.found);
                    check_field("overflow",     o_out_word.overflow,     want.overflow);
                end
                results_seen++;
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                expected_flags.push_back(anagram_step(i_in_word));
                in_taken <= 1'b1;
            end else begin
                in_taken <= 1'b0;
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (!draining && search_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_in_word  <= search_words.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic add_word(t_op op, logic [7:0] sym);
        t_in_word w;
        w.operation = op;
        w.symbol    = sym;
        search_words.push_back(w);
        queued_total++;
    endtask

    task automatic drain_all();
        while (search_words.size() != 0) @(posedge i_clk);
        draining = 1'b1;
        while (i_in_valid || expected_flags.size() != 0) @(posedge i_clk);
        draining = 1'b0;
    endtask

    // one search: clear (usually), pattern, then text, planted anagrams, noise
    task automatic add_search(int forced_len);
        logic [7:0] pat[$];
        logic [7:0] perm[$];
        logic [7:0] tmp;
        int plen;
        int tlen;
        int span;
        int base;
        int n;
        int k;
        int j;
        if (forced_len >= 0 || $urandom_range(9) != 0) add_word(OP_CLEAR, 8'($urandom));
        case ($urandom_range(3))
            0: span = 2;
            1: span = 4;
            2: span = 16;
            default: span = 256;
        endcase
        base = $urandom_range(255);
        if (forced_len >= 0) begin
            plen = forced_len;
        end else begin
            case ($urandom_range(19))
                0: plen = 0;
                1: plen = $urandom_range(MAX_PATTERN - 4, MAX_PATTERN + 3);
                2, 3: plen = $urandom_range(9, MAX_PATTERN);
                default: plen = $urandom_range(1, 8);
            endcase
        end
        for (k = 0; k < plen; k++) begin
            tmp = 8'(base + $urandom_range(span - 1));
            add_word(OP_PATTERN, tmp);
            if (pat.size() < MAX_PATTERN) pat.push_back(tmp);
        end
        tlen = $urandom_range(plen + 2, 2 * plen + 12);
        n = 0;
        while (n < tlen) begin
            case ($urandom_range(29))
                0: begin
                    add_word(t_op'($urandom_range(3)), 8'($urandom));
                    n++;
                end
                1: begin
                    tmp = 8'(base + $urandom_range(span - 1));
                    add_word(OP_PATTERN, tmp);
                    if (pat.size() < MAX_PATTERN) pat.push_back(tmp);
                    n++;
                end
                2, 3, 4, 5, 6, 7: begin
                    if (pat.size() != 0) begin
                        perm = pat;
                        for (k = perm.size() - 1; k > 0; k--) begin
                            j       = $urandom_range(k);
                            tmp     = perm[k];
                            perm[k] = perm[j];
                            perm[j] = tmp;
                        end
                        for (k = 0; k < perm.size(); k++) add_word(OP_TEXT, perm[k]);
                        n += perm.size();
                    end
                end
                default: begin
                    add_word(OP_TEXT, 8'(base + $urandom_range(span - 1)));
                    n++;
                end
            endcase
        end
    endtask

    initial begin
        int idle_mix  [4];
        int stall_mix [4];
        int target;
        int p;
        idle_mix  = '{0, 69, 0, 16};
        stall_mix = '{0, 0, 69, 16};
        for (int k = 0; k < MAX_PATTERN; k++) ring_bytes[k] = 0;
        for (int k = 0; k < ALPHABET; k++) begin
            pattern_count[k] = 0;
            window_count[k]  = 0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty pattern matches every text byte
        add_word(OP_TEXT,    8'h00);
        add_word(OP_TEXT,    8'hFF);
        add_word(OP_UNUSED,  8'hA5);
        add_word(OP_CLEAR,   8'hFF);
        add_word(OP_UNUSED,  8'h5A);
        add_word(OP_PATTERN, 8'h00);
        add_word(OP_PATTERN, 8'hFF);
        add_word(OP_TEXT,    8'hFF);
        add_word(OP_TEXT,    8'h00);
        add_word(OP_TEXT,    8'h00);
        add_word(OP_CLEAR,   8'h00);
        // pattern grows after text: ring bytes count back in
        add_word(OP_TEXT,    8'h11);
        add_word(OP_TEXT,    8'h22);
        add_word(OP_PATTERN, 8'h22);
        add_word(OP_TEXT,    8'h22);
        add_word(OP_PATTERN, 8'h11);
        add_word(OP_TEXT,    8'h11);
        add_word(OP_TEXT,    8'h22);
        add_word(OP_CLEAR,   8'h00);

        for (p = 0; p < 4; p++) begin
            idle_pct  = idle_mix[p];
            stall_pct = stall_mix[p];
            if (p == 0) add_search(MAX_PATTERN + 2);
            target = queued_total + PHASE_WORDS;
            while (queued_total < target) add_search(-1);
            drain_all();
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_flags.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
